// ===== hdl/arr_pkg.sv =====
// Shared types, constants and digit helper for the addressed reading responder.
package arr_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [7:0]  whole_degrees;
    logic [13:0] fraction_ten_thousandths;
  } arr_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_frame;
  } arr_out_t;

  // One accepted request, as queued between front and back
  typedef struct packed {
    logic [7:0]  sof_byte;
    logic [7:0]  address;
    logic [7:0]  whole;
    logic [13:0] frac;
  } arr_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } arr_q_stat_t;

  typedef enum logic {
    CFG_OWN_ADDRESS = 1'b0,
    CFG_FRAME_START = 1'b1
  } arr_cfg_idx_e;

  // Position of a byte within the response frame
  typedef enum logic [3:0] {
    POS_START       = 4'd0,
    POS_ADDRESS     = 4'd1,
    POS_WHOLE_HUNDS = 4'd2,
    POS_WHOLE_TENS  = 4'd3,
    POS_WHOLE_UNITS = 4'd4,
    POS_DOT         = 4'd5,
    POS_FRAC_THOUS  = 4'd6,
    POS_FRAC_HUNDS  = 4'd7,
    POS_FRAC_TENS   = 4'd8,
    POS_FRAC_UNITS  = 4'd9
  } arr_pos_e;

  localparam logic [7:0]  OWN_ADDRESS_RST = 8'h14;
  localparam logic [7:0]  FRAME_START_RST = 8'h96;
  localparam logic [13:0] FRACTION_MAX    = 14'd9999;
  localparam logic [7:0]  ASCII_ZERO      = 8'h30;
  localparam logic [7:0]  ASCII_DOT       = 8'h2E;

  // Leading decimal digit of v for weight w, given v < 10*w
  function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] w);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 14'(14'(k) * w)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

// ===== hdl/arr_chan_if.sv =====
// Valid/ready channel carrying one payload word.
interface arr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/arr_front.sv =====
// Request front end: config registers, frame flag and address match.
module arr_front import arr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  arr_chan_if.sink    in_i,
  input  arr_q_stat_t q_stat_i,
  output logic        push_o,
  output arr_req_t    req_o
);

  logic [7:0] own_addr_q;
  logic [7:0] sof_byte_q;
  logic       armed_q, armed_d;
  logic       acc;
  arr_in_t    din;

  assign din         = in_i.data;
  assign in_i.ready  = !q_stat_i.full;
  assign acc         = in_i.valid && in_i.ready;
  assign push_o      = acc && armed_q && (din.rx_byte == own_addr_q);

  always_comb begin
    req_o.sof_byte = sof_byte_q;
    req_o.address  = own_addr_q;
    req_o.whole    = din.whole_degrees;
    req_o.frac     = (din.fraction_ten_thousandths > FRACTION_MAX) ?
                     FRACTION_MAX : din.fraction_ten_thousandths;
  end

  always_comb begin
    armed_d = armed_q;
    if (acc) begin
      // armed: any byte closes the frame; idle: start byte opens it
      armed_d = armed_q ? 1'b0 : (din.rx_byte == sof_byte_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      own_addr_q <= OWN_ADDRESS_RST;
      sof_byte_q <= FRAME_START_RST;
    end else begin
      armed_q <= armed_d;
      if (cfg_we_i) begin
        case (arr_cfg_idx_e'(cfg_idx_i))
          CFG_OWN_ADDRESS: own_addr_q <= cfg_wdata_i;
          CFG_FRAME_START: sof_byte_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/arr_queue.sv =====
// Small request queue between front end and frame sequencer.
module arr_queue import arr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  arr_req_t    req_i,
  input  logic        pop_i,
  output arr_req_t    req_o,
  output arr_q_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  arr_req_t      slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);
  assign req_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FULL_CNT)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count missed a push");

endmodule

// ===== hdl/arr_back.sv =====
// Frame sequencer: emits the ten response bytes, one byte and at most one decimal digit per step.
module arr_back import arr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arr_q_stat_t q_stat_i,
  input  arr_req_t    req_i,
  output logic        pop_o,
  arr_chan_if.source  out_o
);

  logic        busy_q, busy_d;
  arr_pos_e    pos_q, pos_d;
  logic [7:0]  start_q, addr_q;
  logic [7:0]  whole_rem_q, whole_rem_d;
  logic [13:0] frac_rem_q, frac_rem_d;
  logic        out_vld_q, out_vld_d;
  arr_out_t    out_q, out_d;
  logic        adv, emit, frame_end;
  logic        on_whole, on_digit;
  logic [13:0] dig_val, dig_wt, dig_rem;
  logic [3:0]  dig;
  logic [7:0]  byte_val;

  assign adv       = !out_vld_q || out_o.ready;
  assign emit      = busy_q && adv;
  assign frame_end = emit && (pos_q == POS_FRAC_UNITS);
  assign pop_o     = !q_stat_i.empty && (!busy_q || frame_end);

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // digit weight per frame position
  always_comb begin
    on_whole = 1'b0;
    on_digit = 1'b1;
    dig_wt   = 14'd1;
    case (pos_q)
      POS_WHOLE_HUNDS: begin on_whole = 1'b1; dig_wt = 14'd100;  end
      POS_WHOLE_TENS:  begin on_whole = 1'b1; dig_wt = 14'd10;   end
      POS_WHOLE_UNITS: begin on_whole = 1'b1; dig_wt = 14'd1;    end
      POS_FRAC_THOUS:  dig_wt = 14'd1000;
      POS_FRAC_HUNDS:  dig_wt = 14'd100;
      POS_FRAC_TENS:   dig_wt = 14'd10;
      POS_FRAC_UNITS:  dig_wt = 14'd1;
      default:         on_digit = 1'b0;
    endcase
  end

  assign dig_val = on_whole ? {6'd0, whole_rem_q} : frac_rem_q;
  assign dig     = dec_digit(dig_val, dig_wt);
  assign dig_rem = dig_val - 14'(14'(dig) * dig_wt);

  always_comb begin
    case (pos_q)
      POS_START:   byte_val = start_q;
      POS_ADDRESS: byte_val = addr_q;
      POS_DOT:     byte_val = ASCII_DOT;
      default:     byte_val = ASCII_ZERO + {4'd0, dig};
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    whole_rem_d = whole_rem_q;
    frac_rem_d  = frac_rem_q;
    if (emit) begin
      if (on_digit && on_whole) begin
        whole_rem_d = dig_rem[7:0];
      end else if (on_digit) begin
        frac_rem_d = dig_rem;
      end
      if (frame_end) begin
        busy_d = 1'b0;
        pos_d  = POS_START;
      end else begin
        pos_d = arr_pos_e'(pos_q + 4'd1);
      end
    end
    if (pop_o) begin
      busy_d      = 1'b1;
      pos_d       = POS_START;
      whole_rem_d = req_i.whole;
      frac_rem_d  = req_i.frac;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      out_vld_d           = emit;
      out_d.tx_byte       = byte_val;
      out_d.last_of_frame = (pos_q == POS_FRAC_UNITS);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    whole_rem_q <= whole_rem_d;
    frac_rem_q  <= frac_rem_d;
    if (pop_o) begin
      start_q <= req_i.sof_byte;
      addr_q  <= req_i.address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pos_q     <= POS_START;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== hdl/addressed_reading_responder.sv =====
// Bus slave answering a start byte plus its address with a ten-byte ASCII temperature word
// stream: start byte, address, three whole digits, '.', four fraction digits, last word
// marked. Input words are taken every cycle while the request queue (QUEUE_DEPTH entries)
// has room; a matching request then occupies the frame sequencer for its ten output words,
// one output word per cycle while the output is ready, and a queued request follows with no
// gap. The sequencer forms one byte, and at most one decimal digit, per output word.
module addressed_reading_responder import arr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  arr_chan_if.sink   in_i,
  arr_chan_if.source out_o
);

  arr_q_stat_t q_stat;
  arr_req_t    push_req, pop_req;
  logic        push, pop;

  arr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .req_o       (push_req)
  );

  arr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (push_req),
    .pop_i  (pop),
    .req_o  (pop_req),
    .stat_o (q_stat)
  );

  arr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .req_i    (pop_req),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
